// ----- rtl/rte_pkg.sv -----
// shared types, constants and codes of the ready task election block
package rte_pkg;

	localparam int TASK_SLOTS = 16;
	localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_ELECT = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_LOW  = 2'd1;
	localparam logic [1:0] CFG_HIGH = 2'd2;

	localparam logic MODE_SJF   = 1'b0;
	localparam logic MODE_AGING = 1'b1;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_ELECT,
		OP_READ,
		OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_DECIDE,
		ST_UPD_LEAST,
		ST_UPD_PICK,
		ST_PUSH
	} back_state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  slot;
		logic        ready_in;
		logic [23:0] duration_in;
		logic [7:0]  priority_in;
		logic [15:0] cpu_use_in;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [3:0]  slot_out;
		logic        ready_out;
		logic [23:0] duration_out;
		logic [7:0]  priority_out;
		logic [15:0] cpu_use_out;
	} res_t;

	typedef struct packed {
		logic        ready;
		logic [23:0] duration;
		logic [7:0]  prio;
		logic [15:0] cpu;
	} entry_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] slot;
		entry_t     ent;
	} cmd_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] low;
		logic [7:0] high;
	} cfg_t;

endpackage

// ----- rtl/rte_front.sv -----
// front end: request classification and two-entry command queue
module rte_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  rte_pkg::req_t req,
	input  logic          cmd_pop,
	output logic          cmd_empty,
	output rte_pkg::cmd_t cmd
);

	rte_pkg::cmd_t cmd_in;
	rte_pkg::cmd_t buf_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          in_range;
	logic          do_push;
	logic          do_pop;

	always_comb begin
		in_range        = (32'(req.slot) < 32'(rte_pkg::TASK_SLOTS));
		cmd_in.slot     = req.slot;
		cmd_in.ent      = '{ready: req.ready_in, duration: req.duration_in,
		                    prio: req.priority_in, cpu: req.cpu_use_in};
		unique case (req.req_type)
			rte_pkg::REQ_WRITE: cmd_in.op = in_range ? rte_pkg::OP_WRITE : rte_pkg::OP_NOP;
			rte_pkg::REQ_ELECT: cmd_in.op = rte_pkg::OP_ELECT;
			rte_pkg::REQ_READ:  cmd_in.op = in_range ? rte_pkg::OP_READ : rte_pkg::OP_NOP;
			default:            cmd_in.op = rte_pkg::OP_NOP;
		endcase
	end

	assign full      = (count_q == 2'd2);
	assign cmd_empty = (count_q == 2'd0);
	assign cmd       = buf_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && !cmd_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) buf_q[wr_ptr_q] <= cmd_in;
	end

endmodule

// ----- rtl/rte_back.sv -----
// back end: task table memory, election sequencer and configuration registers
module rte_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_wdata,
	input  logic          cmd_empty,
	input  rte_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output rte_pkg::res_t res_out
);

	rte_pkg::back_state_t state_q, state_d;
	rte_pkg::cfg_t        cfg_q;

	rte_pkg::entry_t mem [rte_pkg::TASK_SLOTS];
	logic [rte_pkg::TASK_SLOTS-1:0] written_q;
	rte_pkg::entry_t rd_q;
	logic            rd_valid_q;
	rte_pkg::entry_t cur;

	logic                      rd_en;
	logic [rte_pkg::SLOT_W-1:0] rd_addr;
	logic                      wr_en;
	logic [rte_pkg::SLOT_W-1:0] wr_addr;
	rte_pkg::entry_t           wr_data;

	logic [rte_pkg::CNT_W-1:0]  cnt_q;
	logic                       eval_v_q;
	logic [rte_pkg::SLOT_W-1:0] eval_idx_q;
	logic                       have_q;
	rte_pkg::entry_t            pick_q;
	logic [rte_pkg::SLOT_W-1:0] pick_idx_q;
	rte_pkg::entry_t            least_q;
	logic [rte_pkg::SLOT_W-1:0] least_idx_q;
	logic [3:0]                 slot_q;
	rte_pkg::res_t              res_q;

	logic            take_pick;
	logic            take_least;
	logic            scan_end;
	logic [7:0]      least_new;
	logic [7:0]      pick_new;
	rte_pkg::entry_t pick_upd;

	function automatic rte_pkg::res_t report(logic [3:0] slot, rte_pkg::entry_t e);
		rte_pkg::res_t r;
		r.found        = 1'b1;
		r.slot_out     = slot;
		r.ready_out    = e.ready;
		r.duration_out = e.duration;
		r.priority_out = e.prio;
		r.cpu_use_out  = e.cpu;
		return r;
	endfunction

	assign res_out  = res_q;
	assign cur      = rd_valid_q ? rd_q : '0;
	assign scan_end = (cnt_q == rte_pkg::CNT_W'(rte_pkg::TASK_SLOTS));

	always_comb begin
		take_pick = cur.ready && (!have_q || ((cfg_q.mode == rte_pkg::MODE_SJF) ?
		            (cur.duration < pick_q.duration) : (cur.prio > pick_q.prio)));
		take_least = cur.ready && (!have_q || (cur.cpu < least_q.cpu));
		least_new  = (least_q.prio < cfg_q.high) ? least_q.prio + 8'd1 : cfg_q.high;
		pick_new   = (pick_q.prio > cfg_q.low) ? pick_q.prio - 8'd1 : cfg_q.low;
		pick_upd      = pick_q;
		pick_upd.prio = pick_new;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rte_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and table access
	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = '0;
		unique case (state_q)
			rte_pkg::ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						rte_pkg::OP_WRITE: begin
							wr_en   = 1'b1;
							wr_addr = rte_pkg::SLOT_W'(cmd.slot);
							wr_data = cmd.ent;
							state_d = rte_pkg::ST_PUSH;
						end
						rte_pkg::OP_READ: begin
							rd_en   = 1'b1;
							rd_addr = rte_pkg::SLOT_W'(cmd.slot);
							state_d = rte_pkg::ST_READ;
						end
						rte_pkg::OP_ELECT: state_d = rte_pkg::ST_SCAN;
						rte_pkg::OP_NOP:   state_d = rte_pkg::ST_PUSH;
					endcase
				end
			end
			rte_pkg::ST_READ: state_d = rte_pkg::ST_PUSH;
			rte_pkg::ST_SCAN: begin
				if (!scan_end) begin
					rd_en   = 1'b1;
					rd_addr = cnt_q[rte_pkg::SLOT_W-1:0];
				end else begin
					state_d = rte_pkg::ST_DECIDE;
				end
			end
			rte_pkg::ST_DECIDE: begin
				if (have_q && cfg_q.mode == rte_pkg::MODE_AGING) begin
					state_d = rte_pkg::ST_UPD_LEAST;
				end else begin
					state_d = rte_pkg::ST_PUSH;
				end
			end
			rte_pkg::ST_UPD_LEAST: begin
				wr_en        = 1'b1;
				wr_addr      = least_idx_q;
				wr_data      = least_q;
				wr_data.prio = least_new;
				state_d      = rte_pkg::ST_UPD_PICK;
			end
			rte_pkg::ST_UPD_PICK: begin
				wr_en        = 1'b1;
				wr_addr      = pick_idx_q;
				wr_data      = pick_q;
				wr_data.prio = pick_new;
				state_d      = rte_pkg::ST_PUSH;
			end
			rte_pkg::ST_PUSH: begin
				res_push = 1'b1;
				if (!res_full) state_d = rte_pkg::ST_IDLE;
			end
			default: state_d = rte_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q     <= '{mode: rte_pkg::MODE_AGING, low: 8'd0, high: 8'd15};
			written_q <= '0;
			cnt_q     <= '0;
			eval_v_q  <= 1'b0;
			have_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					rte_pkg::CFG_MODE: cfg_q.mode <= cfg_wdata[0];
					rte_pkg::CFG_LOW:  cfg_q.low  <= cfg_wdata;
					rte_pkg::CFG_HIGH: cfg_q.high <= cfg_wdata;
					default:           cfg_q      <= cfg_q;
				endcase
			end
			if (wr_en) written_q[wr_addr] <= 1'b1;
			eval_v_q <= rd_en && (state_q == rte_pkg::ST_SCAN);
			if (state_q == rte_pkg::ST_IDLE) begin
				cnt_q  <= '0;
				have_q <= 1'b0;
			end else if (state_q == rte_pkg::ST_SCAN) begin
				if (!scan_end) cnt_q <= cnt_q + rte_pkg::CNT_W'(1);
				if (eval_v_q && cur.ready) have_q <= 1'b1;
			end
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			rd_valid_q <= written_q[rd_addr];
		end
	end

	// election datapath and result
	always_ff @(posedge clk) begin
		if (rd_en) eval_idx_q <= rd_addr;
		if (state_q == rte_pkg::ST_SCAN && eval_v_q) begin
			if (take_pick) begin
				pick_q     <= cur;
				pick_idx_q <= eval_idx_q;
			end
			if (take_least) begin
				least_q     <= cur;
				least_idx_q <= eval_idx_q;
			end
		end
		if (state_q == rte_pkg::ST_UPD_LEAST && pick_idx_q == least_idx_q) begin
			pick_q.prio <= least_new;
		end
		unique case (state_q)
			rte_pkg::ST_IDLE: begin
				if (cmd.op == rte_pkg::OP_WRITE) begin
					res_q <= report(cmd.slot, cmd.ent);
				end else begin
					res_q <= '0;
				end
				slot_q <= cmd.slot;
			end
			rte_pkg::ST_READ: res_q <= report(slot_q, cur);
			rte_pkg::ST_DECIDE: begin
				if (have_q) begin
					res_q <= report(4'(pick_idx_q), pick_q);
				end else begin
					res_q <= '0;
				end
			end
			rte_pkg::ST_UPD_PICK: res_q <= report(4'(pick_idx_q), pick_upd);
			default: res_q <= res_q;
		endcase
	end

endmodule

// ----- rtl/rte_res_queue.sv -----
// two-entry result queue toward the consumer
module rte_res_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	input  rte_pkg::res_t res_in,
	output logic          res_full,
	output logic          empty,
	input  logic          pop,
	output rte_pkg::res_t res
);

	rte_pkg::res_t buf_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	assign res_full = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign res      = buf_q[rd_ptr_q];
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) buf_q[wr_ptr_q] <= res_in;
	end

endmodule

// ----- rtl/ready_task_election.sv -----
// top level of the ready task election block
// Task table of TASK_SLOTS entries (ready, duration, priority, CPU use) with write,
// read and election requests; every request gives exactly one result, in order.
// Requests enter a two-entry command queue and results leave through a two-entry
// result queue, so both sides stall independently. The back end serves one request
// at a time through a single-port table memory: a write or an invalid request goes
// straight to the result push, a read passes through a read state, and an election
// scans the table one entry per cycle, then decides and, in aging mode when a ready
// task was found, does two priority write-backs before the result push. Entries
// carry per-slot valid flip-flops cleared by reset, so no clearing pass is needed.
// Configuration writes are taken at any time but are meant for idle periods.
module ready_task_election (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  rte_pkg::req_t req,
	output logic          empty,
	input  logic          pop,
	output rte_pkg::res_t res,
	input  logic          cfg_wr_en,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_wdata
);

	rte_pkg::cmd_t cmd;
	logic          cmd_empty;
	logic          cmd_pop;
	rte_pkg::res_t res_in;
	logic          res_push;
	logic          res_full;

	rte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.cmd_pop   (cmd_pop),
		.cmd_empty (cmd_empty),
		.cmd       (cmd)
	);

	rte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd_empty (cmd_empty),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_out   (res_in)
	);

	rte_res_queue u_res_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_in),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.res      (res)
	);

`ifndef NO_ASSERTIONS
	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command taken from an empty queue");

	a_slot_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.found) |-> ((rte_pkg::TASK_SLOTS > 16) ||
		(32'(res.slot_out) < 32'(rte_pkg::TASK_SLOTS))))
		else $error("result reports a slot outside the table");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !res.found) |-> (res.slot_out == 4'd0 && res.ready_out == 1'b0 &&
		res.duration_out == 24'd0 && res.priority_out == 8'd0 && res.cpu_use_out == 16'd0))
		else $error("miss result carries nonzero entry data");
`endif

endmodule
